// ----- sv/rmpf_pkg.sv -----
// ----------------------------------------------------------------------------
// rmpf_pkg: shared types and constants
// Request codes, field widths and defaults of the running mean block.
// ----------------------------------------------------------------------------
`default_nettype none
package rmpf_pkg;
  localparam int unsigned ImgWidthDef  = 64;
  localparam int unsigned ImgHeightDef = 64;
  localparam int unsigned CoordW       = 6;
  localparam int unsigned FrameCntW    = 16;
  localparam logic [7:0]  TolReset     = 8'd30;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [1:0] ReqLoad   = 2'd0;
  localparam logic [1:0] ReqUpdate = 2'd1;
  localparam logic [1:0] ReqEof    = 2'd2;

  localparam logic RegTolerance = 1'b0;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]        req_type;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [7:0]        blue;
    logic [7:0]        red;
  } req_t;

  typedef struct packed {
    logic [7:0] mean_value;
    logic       replaced;
    logic       hit_border;
  } rsp_t;
endpackage
`default_nettype wire

// ----- sv/rmpf_req_if.sv -----
// ----------------------------------------------------------------------------
// rmpf_req_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none
interface rmpf_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [rmpf_pkg::CoordW-1:0] col;
  logic [rmpf_pkg::CoordW-1:0] row;
  logic [7:0]                blue;
  logic [7:0]                red;
  modport source (output valid, req_type, col, row, blue, red, input ready);
  modport sink   (input valid, req_type, col, row, blue, red, output ready);
endinterface
`default_nettype wire

// ----- sv/rmpf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rmpf_rsp_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface rmpf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] mean_value;
  logic       replaced;
  logic       hit_border;
  modport source (output valid, mean_value, replaced, hit_border, input ready);
  modport sink   (input valid, mean_value, replaced, hit_border, output ready);
endinterface
`default_nettype wire

// ----- sv/running_mean_with_pixel_fallback_core.sv -----
// ----------------------------------------------------------------------------
// running_mean_with_pixel_fallback_core: top level
// Per-pixel running mean of blue with a diagonal fallback walk.
// ----------------------------------------------------------------------------
// Usage: requests enter on the req channel (valid/ready) and each gives
// exactly one item on the rsp channel. A load writes one pixel inside the
// image into the frame memory, an end-of-frame bumps the saturating frame
// counter; with an idle back end both show a zero result, registered in
// the queue and then in the back end. An update reads its pixel, walks
// one pixel a cycle toward the centre while the pixel fails the tolerance
// or has zero blue (fewer steps than the smaller image dimension, ending
// at the image border), then runs a bit-serial restoring divide by the
// frame count. The back end takes the next item only after the last
// result is taken. Items run one at a time in the back end; a two-entry
// queue keeps accepting while a result waits. A stalled rsp holds its
// item and the back end waits. Reset sets the frame count to one and the
// tolerance to 30; memories are not cleared. The tolerance register sits
// at APB address 0.
// ----------------------------------------------------------------------------
`default_nettype none
module running_mean_with_pixel_fallback_core #(
  parameter int unsigned ImgWidth  = rmpf_pkg::ImgWidthDef,
  parameter int unsigned ImgHeight = rmpf_pkg::ImgHeightDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  rmpf_req_if.sink         req,
  rmpf_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rmpf_pkg::*;

  logic       q_valid, q_pop;
  req_t       q_data;
  logic [7:0] tol_q;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tol_q <= TolReset;
    else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && RegTolerance == 1'b0)
      tol_q <= pwdata[7:0];
  end
  assign prdata = (paddr == 2'b00) ? {24'd0, tol_q} : 32'd0;

  rmpf_front u_front (
    .clk_i, .rst_ni, .req, .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop));

  rmpf_back #(.ImgWidth(ImgWidth), .ImgHeight(ImgHeight)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .tolerance_i(tol_q), .rsp);
endmodule
`default_nettype wire

// ----- sv/rmpf_ram.sv -----
// ----------------------------------------------------------------------------
// rmpf_ram: generic single-port ram
// One access per cycle at a single address (a write also reads the old data), registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rmpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- sv/rmpf_front.sv -----
// ----------------------------------------------------------------------------
// rmpf_front: request intake and queue
// Accepts request items and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rmpf_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  rmpf_req_if.sink            req,
  output logic                q_valid_o,
  output rmpf_pkg::req_t      q_data_o,
  input  wire logic           q_pop_i
);
  import rmpf_pkg::*;
  localparam int unsigned PtrW = $clog2(QueueDepth);

  req_t            buf_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push;

  assign req.ready = (cnt_q != QueueDepth[PtrW:0]);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = buf_q[rd_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{req.req_type, req.col, req.row, req.blue, req.red};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (q_pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

// ----- sv/rmpf_back.sv -----
// ----------------------------------------------------------------------------
// rmpf_back: request execution
// Stores pixels, runs the diagonal walk and the iterative mean update.
// ----------------------------------------------------------------------------
`default_nettype none
module rmpf_back #(
  parameter int unsigned ImgWidth  = 64,
  parameter int unsigned ImgHeight = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  rmpf_pkg::req_t      q_data_i,
  output logic                q_pop_o,
  input  wire logic [7:0]     tolerance_i,
  rmpf_rsp_if.source          rsp
);
  import rmpf_pkg::*;
  localparam int unsigned XW = $clog2(ImgWidth);
  localparam int unsigned YW = $clog2(ImgHeight);
  localparam int unsigned AW = $clog2(ImgWidth * ImgHeight);
  localparam int unsigned CW = (XW > CoordW) ? XW : CoordW;
  localparam int unsigned RW = (YW > CoordW) ? YW : CoordW;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StCheck = 7'b0000100,
    StWalk  = 7'b0001000,
    StMean  = 7'b0010000,
    StDiv   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e               st_q, st_d;
  logic [XW-1:0]        cx_q, x0_q;
  logic [YW-1:0]        cy_q, y0_q;
  logic                 dx_neg_q, dy_neg_q, rep_q, bord_q, first_q;
  logic [7:0]           blue_q, mean_q, res_q;
  logic [FrameCntW-1:0] fc_q;
  logic [4:0]           bit_q;
  logic [8:0]           num_q;
  logic [FrameCntW:0]   rem_q;
  logic [8:0]           quo_q;
  logic                 neg_q;
  logic                 rsp_valid_q;
  rsp_t                 rsp_q;

  logic          fs_we, ms_we;
  logic [AW-1:0] fs_addr, ms_addr;
  logic [15:0]   fs_rdata;
  logic [7:0]    ms_rdata, ms_wdata;

  req_t          rq;
  logic          in_img;
  logic [AW-1:0] home_addr;
  assign rq        = q_data_i;
  assign in_img    = ((CW+1)'(rq.col) < (CW+1)'(ImgWidth)) &&
                     ((RW+1)'(rq.row) < (RW+1)'(ImgHeight));
  assign home_addr = AW'(y0_q) * AW'(ImgWidth) + AW'(x0_q);

  // pixel checks on the frame read
  logic [7:0] pb, pr, ad;
  logic       tol_ok, at_border;
  assign pb        = fs_rdata[7:0];
  assign pr        = fs_rdata[15:8];
  assign ad        = (pb > pr) ? pb - pr : pr - pb;
  assign tol_ok    = ad <= tolerance_i;
  assign at_border = (dx_neg_q ? (cx_q == '0) : (cx_q == XW'(ImgWidth - 1))) ||
                     (dy_neg_q ? (cy_q == '0) : (cy_q == YW'(ImgHeight - 1)));

  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  assign nx = dx_neg_q ? cx_q - 1'b1 : cx_q + 1'b1;
  assign ny = dy_neg_q ? cy_q - 1'b1 : cy_q + 1'b1;

  // first frame: old mean does not matter, the blue value is taken as is
  logic [7:0] mean_rd;
  assign mean_rd = (fc_q == FrameCntW'(1)) ? 8'd0 : ms_rdata;

  logic idle_take;
  assign idle_take = (st_q == StIdle) && q_valid_i && !rsp_valid_q;
  assign q_pop_o   = idle_take;

  // store addressing
  always_comb begin
    fs_we    = 1'b0;
    fs_addr  = AW'(cy_q) * AW'(ImgWidth) + AW'(cx_q);
    ms_we    = 1'b0;
    ms_addr  = home_addr;
    ms_wdata = res_q;
    if (idle_take) begin
      fs_addr = AW'(RW'(rq.row)) * AW'(ImgWidth) + AW'(CW'(rq.col));
      fs_we   = (rq.req_type == ReqLoad) && in_img;
    end else if (st_q == StWalk) begin
      fs_addr = AW'(ny) * AW'(ImgWidth) + AW'(nx);
    end
    if (st_q == StOut) ms_we = 1'b1;
  end

  rmpf_ram #(.Width(16), .Depth(ImgWidth * ImgHeight)) u_frame (
    .clk_i, .we_i(fs_we), .addr_i(fs_addr), .wdata_i({rq.red, rq.blue}),
    .rdata_o(fs_rdata));
  rmpf_ram #(.Width(8), .Depth(ImgWidth * ImgHeight)) u_mean (
    .clk_i, .we_i(ms_we), .addr_i(ms_addr), .wdata_i(ms_wdata), .rdata_o(ms_rdata));

  // divide step: restoring, one quotient bit a cycle
  logic [FrameCntW:0] trial;
  logic               q_bit;
  assign trial = {rem_q[FrameCntW-1:0], num_q[8]};
  assign q_bit = (trial >= {1'b0, fc_q});

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      fc_q        <= FrameCntW'(1);
      rsp_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
      if (idle_take) begin
        if (rq.req_type == ReqEof && fc_q != '1) fc_q <= fc_q + 1'b1;
        if (rq.req_type != ReqUpdate || !in_img) rsp_valid_q <= 1'b1;
      end
      if (st_q == StOut) rsp_valid_q <= 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (idle_take && rq.req_type == ReqUpdate && in_img) st_d = StRead;
      StRead:  st_d = StCheck;
      StCheck: st_d = StWalk;
      StWalk:  if ((pb != 8'd0 && tol_ok) || !rep_q || at_border) st_d = StMean;
      StMean:  st_d = StDiv;
      StDiv:   if (bit_q == 5'd0) st_d = StOut;
      StOut:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (idle_take) begin
        x0_q     <= XW'(rq.col);
        y0_q     <= YW'(rq.row);
        cx_q     <= XW'(rq.col);
        cy_q     <= YW'(rq.row);
        dx_neg_q <= !(CW'(rq.col) < CW'(ImgWidth / 2));
        dy_neg_q <= !(RW'(rq.row) < RW'(ImgHeight / 2));
        rep_q    <= 1'b0;
        bord_q   <= 1'b0;
        first_q  <= 1'b1;
        rsp_q    <= '0;
      end
      StCheck: begin
        // walk starts only if home pixel fails tolerance
        rep_q  <= !tol_ok;
        blue_q <= pb;
        if (!tol_ok && at_border) bord_q <= 1'b1;
      end
      StWalk: begin
        first_q <= 1'b0;
        if (!first_q) blue_q <= pb;
        if (rep_q && !(!first_q && pb != 8'd0 && tol_ok) && !(first_q && at_border)) begin
          if (!first_q && at_border) bord_q <= 1'b1;
        end
        if (!at_border) begin
          cx_q <= nx;
          cy_q <= ny;
        end
      end
      StMean: begin
        mean_q <= mean_rd;
        neg_q  <= blue_q < mean_rd;
        num_q  <= (blue_q < mean_rd) ? 9'(mean_rd - blue_q) : 9'(blue_q - mean_rd);
        rem_q  <= '0;
        quo_q  <= '0;
        bit_q  <= 5'd8;
      end
      StDiv: begin
        num_q <= {num_q[7:0], 1'b0};
        if (q_bit) begin
          rem_q <= trial - {1'b0, fc_q};
          quo_q <= {quo_q[7:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[7:0], 1'b0};
        end
        bit_q <= bit_q - 1'b1;
        if (bit_q == 5'd0) begin
          res_q <= neg_q ? mean_q - {quo_q[6:0], q_bit}
                         : mean_q + {quo_q[6:0], q_bit};
        end
      end
      StOut: rsp_q <= '{res_q, rep_q, bord_q};
      default: ;
    endcase
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.mean_value = rsp_q.mean_value;
  assign rsp.replaced   = rsp_q.replaced;
  assign rsp.hit_border = rsp_q.hit_border;
endmodule
`default_nettype wire
